@@ sv/ggsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Gaussian glow sprite package
// Widths, register indexes, stage records and the exponent table of the
// glow sprite pixel pipeline.
// ----------------------------------------------------------------------------
package ggsp_pkg;

  localparam int PIX_W        = 6;
  localparam int DIAM_W       = 7;
  localparam int SIGMA_W      = 8;
  localparam int CFG_W        = 8;
  localparam int INT_W        = 8;
  localparam int MAX_DIAMETER = 64;

  localparam int NDIV    = 20;
  localparam int NMUL    = 20;
  localparam int SQ_BITS = 15;

  localparam logic [DIAM_W-1:0]  DIAM_RESET  = 7'd16;
  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 8'd64;
  localparam logic [14:0]        FADE_LEN    = 15'd768;
  localparam logic [17:0]        RECIP3      = 18'd174763;
  localparam logic [16:0]        G_ONE       = 17'h10000;

  typedef enum logic {
    REG_DIAMETER = 1'b0,
    REG_SIGMA    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] hx;
    logic [7:0] hy;
  } ofs_t;

  typedef struct packed {
    logic        kz;
    logic [15:0] r;
    logic [19:0] arg;
    logic [14:0] root;
    logic [29:0] rem;
  } ds_t;

  typedef struct packed {
    logic [16:0] g;
    logic [19:0] arg;
    logic        fade;
    logic [9:0]  e;
  } ml_t;

  typedef struct packed {
    logic        fade;
    logic [17:0] x;
  } fd_t;

  function automatic logic [15:0] exp_tab(input logic [4:0] idx);
    logic [15:0] v;
    unique case (idx)
      5'd0:    v = 16'd65535;
      5'd1:    v = 16'd65534;
      5'd2:    v = 16'd65532;
      5'd3:    v = 16'd65528;
      5'd4:    v = 16'd65520;
      5'd5:    v = 16'd65504;
      5'd6:    v = 16'd65472;
      5'd7:    v = 16'd65408;
      5'd8:    v = 16'd65280;
      5'd9:    v = 16'd65026;
      5'd10:   v = 16'd64520;
      5'd11:   v = 16'd63520;
      5'd12:   v = 16'd61565;
      5'd13:   v = 16'd57835;
      5'd14:   v = 16'd51039;
      5'd15:   v = 16'd39750;
      5'd16:   v = 16'd24109;
      5'd17:   v = 16'd8869;
      5'd18:   v = 16'd1200;
      5'd19:   v = 16'd22;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/gaussian_glow_sprite_pixel.sv @@
// ----------------------------------------------------------------------------
// Gaussian glow sprite pixel
// Computes one 8-bit radial Gaussian glow intensity per pixel coordinate.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock while the output is not stalled
// and returns one intensity beat per pixel, in order. The pipeline holds the
// 20 stages of the restoring divider that forms the exponent argument,
// followed by the 20 stages of the exponent table multiply chain; the square
// root runs beside the divider. A stall at the output freezes the whole
// pipeline. Configuration is not captured per pixel: later stages read the
// live registers, so a write also reaches pixels already in flight.
module gaussian_glow_sprite_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ggsp_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ggsp_pkg::PIX_W-1:0]    pix_x_i,
  input  logic [ggsp_pkg::PIX_W-1:0]    pix_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ggsp_pkg::INT_W-1:0]    intensity_o
);
  import ggsp_pkg::*;

  logic [DIAM_W-1:0]  diameter_q;
  logic [SIGMA_W-1:0] sigma_q;
  logic [DIAM_W-1:0]  d_eff;
  logic [SIGMA_W-1:0] s_eff;
  logic [12:0]        dsq_q;
  logic [15:0]        s2_q;

  logic            en;
  logic            va_q, vb_q, vf1_q, vf2_q, vo_q;
  logic [NDIV-1:0] vds_q;
  logic [NMUL-1:0] vml_q;

  ofs_t a_d, a_q;
  ds_t  dsi_d, dsi_q;
  ds_t  ds_n [NDIV];
  ds_t  ds_q [NDIV];
  ml_t  ml_n [NMUL];
  ml_t  ml_q [NMUL];
  ml_t  ml0;
  fd_t  f1_d, f1_q;
  logic [16:0] f2_d, f2_q;
  logic [INT_W-1:0] out_d, out_q;

  logic [8:0]         hx9, hy9;
  logic signed [15:0] sqx, sqy;
  logic [15:0]        q16;
  logic [14:0]        q;
  logic               inr, kz;
  logic [12:0]        qe;
  logic [14:0]        e15;
  logic [26:0]        p1;
  logic [35:0]        p2;
  logic [24:0]        p3;

  assign d_eff = (diameter_q > DIAM_W'(MAX_DIAMETER)) ? DIAM_W'(MAX_DIAMETER) : diameter_q;
  assign s_eff = (sigma_q == '0) ? SIGMA_W'(1) : sigma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diameter_q <= DIAM_RESET;
      sigma_q    <= SIGMA_RESET;
      dsq_q      <= 13'd256;
      s2_q       <= 16'd4096;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_DIAMETER: diameter_q <= cfg_wdata_i[DIAM_W-1:0];
          REG_SIGMA:    sigma_q    <= cfg_wdata_i[SIGMA_W-1:0];
          default:      ;
        endcase
      end
      dsq_q <= 13'(d_eff * d_eff);
      s2_q  <= 16'(s_eff * s_eff);
    end
  end

  assign out_valid_o = vo_q;
  assign intensity_o = out_q;
  assign en          = !vo_q || out_ready_i;
  assign in_ready_o  = en;

  always_comb begin
    hx9    = {2'b00, pix_x_i, 1'b0} - {2'b00, d_eff} + 9'd1;
    hy9    = {2'b00, pix_y_i, 1'b0} - {2'b00, d_eff} + 9'd1;
    a_d.hx = hx9[7:0];
    a_d.hy = hy9[7:0];
  end

  always_comb begin
    sqx = $signed(a_q.hx) * $signed(a_q.hx);
    sqy = $signed(a_q.hy) * $signed(a_q.hy);
    q16 = 16'(sqx) + 16'(sqy);
    q   = q16[14:0];
    inr = (q <= {2'b00, dsq_q});
    kz  = !inr || ({q, 1'b0} >= s2_q);
    qe  = inr ? q[12:0] : '0;
    dsi_d.kz   = kz;
    dsi_d.r    = kz ? '0 : {2'b00, qe, 1'b0};
    dsi_d.arg  = '0;
    dsi_d.root = '0;
    dsi_d.rem  = {1'b0, qe, 16'd0};
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    ds_t         cur;
    logic [16:0] r2;
    logic [14:0] root_n;
    logic [29:0] rem_n;
    if (k == 0) begin : g_first
      assign cur = dsi_q;
    end else begin : g_next
      assign cur = ds_q[k-1];
    end
    if (k < SQ_BITS) begin : g_sq
      localparam int B = SQ_BITS - 1 - k;
      logic [29:0] trial;
      assign trial  = ({15'd0, cur.root} << (B + 1)) + (30'd1 << (2 * B));
      assign rem_n  = (cur.rem >= trial) ? cur.rem - trial : cur.rem;
      assign root_n = (cur.rem >= trial) ? (cur.root | (15'd1 << B)) : cur.root;
    end else begin : g_nosq
      assign rem_n  = cur.rem;
      assign root_n = cur.root;
    end
    always_comb begin
      ds_n[k]      = cur;
      ds_n[k].rem  = rem_n;
      ds_n[k].root = root_n;
      r2           = {cur.r, 1'b0};
      if (r2 >= {1'b0, s2_q}) begin
        ds_n[k].r               = 16'(r2 - {1'b0, s2_q});
        ds_n[k].arg[NDIV-1-k]   = 1'b1;
      end else begin
        ds_n[k].r = r2[15:0];
      end
    end
  end

  always_comb begin
    e15      = {d_eff, 8'd0} - ds_q[NDIV-1].root;
    ml0.g    = ds_q[NDIV-1].kz ? '0 : G_ONE;
    ml0.arg  = ds_q[NDIV-1].arg;
    ml0.fade = (e15 < FADE_LEN);
    ml0.e    = e15[9:0];
  end

  for (genvar m = 0; m < NMUL; m++) begin : g_mul
    ml_t         cur;
    logic [32:0] prod;
    if (m == 0) begin : g_first
      assign cur = ml0;
    end else begin : g_next
      assign cur = ml_q[m-1];
    end
    always_comb begin
      prod    = cur.g * exp_tab(5'(m));
      ml_n[m] = cur;
      if (cur.arg[m]) begin
        ml_n[m].g = prod[32:16];
      end
    end
  end

  always_comb begin
    p1      = ml_q[NMUL-1].g * ml_q[NMUL-1].e;
    f1_d.fade = ml_q[NMUL-1].fade;
    f1_d.x    = ml_q[NMUL-1].fade ? p1[25:8] : {1'b0, ml_q[NMUL-1].g};
    p2      = f1_q.x * RECIP3;
    f2_d    = f1_q.fade ? p2[35:19] : f1_q.x[16:0];
    p3      = {f2_q, 8'd0} - {8'd0, f2_q};
    out_d   = p3[23:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      vds_q <= '0;
      vml_q <= '0;
      vf1_q <= 1'b0;
      vf2_q <= 1'b0;
      vo_q  <= 1'b0;
    end else if (en) begin
      va_q  <= in_valid_i;
      vb_q  <= va_q;
      vds_q <= {vds_q[NDIV-2:0], vb_q};
      vml_q <= {vml_q[NMUL-2:0], vds_q[NDIV-1]};
      vf1_q <= vml_q[NMUL-1];
      vf2_q <= vf1_q;
      vo_q  <= vf2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= a_d;
      dsi_q <= dsi_d;
      for (int k = 0; k < NDIV; k++) begin
        ds_q[k] <= ds_n[k];
      end
      for (int m = 0; m < NMUL; m++) begin
        ml_q[m] <= ml_n[m];
      end
      f1_q  <= f1_d;
      f2_q  <= f2_d;
      out_q <= out_d;
    end
  end

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vds_q) && $stable(vml_q))
    else $error("pipeline valid bits moved during a stall");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vds_q[NDIV-1] && !ds_q[NDIV-1].kz |-> ds_q[NDIV-1].r < s2_q)
    else $error("divider remainder not below divisor");

  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vds_q[NDIV-1] |-> ds_q[NDIV-1].rem <= {14'd0, ds_q[NDIV-1].root, 1'b0})
    else $error("square root remainder too large");

  a_gain_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vf2_q |-> f2_q <= G_ONE)
    else $error("glow gain above one");

endmodule
